@@ design/src_pkg.sv @@
package src_pkg;

    // Reading kinds carried in the input and output tuser fields.
    localparam logic [1:0] KIND_TEMP  = 2'd0;
    localparam logic [1:0] KIND_PRESS = 2'd1;
    localparam logic [1:0] KIND_HUM   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_TEMP_CAL   = 3'd0;
    localparam logic [2:0] REG_PRESS_LOW  = 3'd1;
    localparam logic [2:0] REG_PRESS_HIGH = 3'd2;
    localparam logic [2:0] REG_PRESS_LAST = 3'd3;
    localparam logic [2:0] REG_HUM_CAL    = 3'd4;

    localparam int WORD_W = 64;
    localparam int CNT_W  = 7;

    // Last step of the temperature and humidity multiply sequences, and the pressure step before the divide.
    localparam logic [3:0] TEMP_LAST_STEP  = 4'd3;
    localparam logic [3:0] PRESS_DIV_STEP  = 4'd6;
    localparam logic [3:0] HUM_LAST_STEP   = 4'd7;

    localparam logic [31:0] HUM_LIMIT = 32'd419430400;

    // Start request for the shared serial arithmetic units.
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } op_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_ISSUE,
        ST_MUL_WAIT,
        ST_DIV_ISSUE,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    // Sign-extend the low 32 bits to a full word.
    function automatic logic [63:0] s32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    // Arithmetic right shift of the low 32 bits, result sign-extended.
    function automatic logic [63:0] asr32(input logic [63:0] v, input int unsigned sh);
        logic signed [31:0] t;
        t = $signed(v[31:0]) >>> sh;
        return {{32{t[31]}}, t};
    endfunction

    // Arithmetic right shift of a full word.
    function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned sh);
        return $unsigned($signed(v) >>> sh);
    endfunction

    // Sign-extend a 16-bit coefficient.
    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

endpackage

@@ design/src_mul.sv @@
// Bit-serial multiplier: one multiplier bit per cycle, product modulo 2^64.
module src_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  src_pkg::op_req_t            req,
    output logic                        done,
    output logic [src_pkg::WORD_W-1:0]  product
);

    logic                       busy_reg;
    logic [src_pkg::WORD_W-1:0] a_reg;
    logic [src_pkg::WORD_W-1:0] b_reg;
    logic [src_pkg::WORD_W-1:0] acc_reg;

    // Finished once all remaining multiplier bits are zero.
    assign done    = busy_reg && (b_reg == '0);
    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    // Shift-and-add datapath.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg && !done)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[src_pkg::WORD_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[src_pkg::WORD_W-1:1]};
        end
    end

endmodule

@@ design/src_div.sv @@
// Signed restoring divider: one quotient bit per cycle, truncating toward zero.
// The divisor must be nonzero.
module src_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  src_pkg::op_req_t            req,
    output logic                        done,
    output logic [src_pkg::WORD_W-1:0]  quotient
);

    logic                       busy_reg;
    logic [src_pkg::CNT_W-1:0]  cnt_reg;
    logic                       neg_reg;
    logic [src_pkg::WORD_W-1:0] rem_reg;
    logic [src_pkg::WORD_W-1:0] quo_reg;
    logic [src_pkg::WORD_W-1:0] den_reg;
    logic [src_pkg::WORD_W:0]   shifted;
    logic [src_pkg::WORD_W:0]   trial;

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = neg_reg ? ('0 - quo_reg) : quo_reg;
    assign shifted  = {rem_reg, quo_reg[src_pkg::WORD_W-1]};
    assign trial    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    // Magnitudes go in at the start; the sign is restored on the way out.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            cnt_reg <= src_pkg::CNT_W'(src_pkg::WORD_W);
            neg_reg <= req.a[src_pkg::WORD_W-1] ^ req.b[src_pkg::WORD_W-1];
            rem_reg <= '0;
            quo_reg <= req.a[src_pkg::WORD_W-1] ? ('0 - req.a) : req.a;
            den_reg <= req.b[src_pkg::WORD_W-1] ? ('0 - req.b) : req.b;
        end
        else if (busy_reg && !done)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (!trial[src_pkg::WORD_W])
            begin
                rem_reg <= trial[src_pkg::WORD_W-1:0];
                quo_reg <= {quo_reg[src_pkg::WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[src_pkg::WORD_W-1:0];
                quo_reg <= {quo_reg[src_pkg::WORD_W-2:0], 1'b0};
            end
        end
    end

endmodule

@@ design/sensor_reading_compensation_unit.sv @@
// Integer compensation of raw temperature, pressure and humidity readings.
// Input stream: tuser carries the reading kind (0 temperature, 1 pressure,
// 2 humidity), tdata the raw converter value. Output stream: one result per
// request, with the kind echoed and a divide-by-zero flag in tuser and the
// three compensated values in tdata (zero for the kinds not requested).
// Calibration words are written through the cfg port only while the unit is
// idle; the user is bound to this, the unit does not enforce it. Multiplies go
// to one shared bit-serial multiplier, the pressure divide to a bit-serial
// divider, each after an issue state. A request takes four multiplies for
// temperature, eight for humidity and eleven operations with the divide for
// pressure (six multiplies when the divisor is zero); the output state then
// loads the output register and returns to idle. The multiplier finishes earlier
// when the multiplier operand is small. One request is processed at a time. A
// temperature request updates the stored fine temperature used by later pressure
// and humidity requests. Reset clears the calibration registers, the fine
// temperature and the output valid flag. A finished result waits in the output
// register while the receiver stalls; a new request is accepted meanwhile, but
// its result is held until the previous one has been taken.
module sensor_reading_compensation_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [19:0] raw_value, zero fill above
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // [31:0] temperature_centi,
                                        // [63:32] pressure_q24_8,
                                        // [80:64] humidity_q7_10, zero fill above
    output logic [2:0]  m_axis_tuser    // [1:0] kind_echo, [2] divide_by_zero
);

    src_pkg::state_t state_reg, state_next;

    logic [47:0] temp_cal_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_last_reg;
    logic [63:0] hum_cal_reg;
    logic [31:0] fine_reg, fine_next;

    logic [1:0]  kind_reg, kind_next;
    logic [19:0] raw_reg, raw_next;
    logic [3:0]  step_reg, step_next;
    logic [63:0] x0_reg, x0_next;
    logic [63:0] x1_reg, x1_next;
    logic [63:0] x2_reg, x2_next;
    logic [63:0] x3_reg, x3_next;
    logic [31:0] temp_res_reg, temp_res_next;
    logic [31:0] press_res_reg, press_res_next;
    logic [16:0] hum_res_reg, hum_res_next;
    logic        dz_res_reg, dz_res_next;

    logic        out_valid_reg, out_valid_next;
    logic [87:0] out_data_reg, out_data_next;
    logic [2:0]  out_user_reg, out_user_next;

    src_pkg::op_req_t mul_req, div_req;
    logic             mul_done, div_done;
    logic [63:0]      prod, quot;

    // Calibration coefficients.
    logic [63:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] h1, h2, h3, h4, h5, h6;
    logic [63:0] pa, hx, raw64, x2s13, hv;

    assign t1 = {48'd0, temp_cal_reg[15:0]};
    assign t2 = src_pkg::sx16(temp_cal_reg[31:16]);
    assign t3 = src_pkg::sx16(temp_cal_reg[47:32]);
    assign p1 = {48'd0, press_low_reg[15:0]};
    assign p2 = src_pkg::sx16(press_low_reg[31:16]);
    assign p3 = src_pkg::sx16(press_low_reg[47:32]);
    assign p4 = src_pkg::sx16(press_low_reg[63:48]);
    assign p5 = src_pkg::sx16(press_high_reg[15:0]);
    assign p6 = src_pkg::sx16(press_high_reg[31:16]);
    assign p7 = src_pkg::sx16(press_high_reg[47:32]);
    assign p8 = src_pkg::sx16(press_high_reg[63:48]);
    assign p9 = src_pkg::sx16(press_last_reg);
    assign h1 = {56'd0, hum_cal_reg[7:0]};
    assign h2 = src_pkg::sx16(hum_cal_reg[23:8]);
    assign h3 = {56'd0, hum_cal_reg[31:24]};
    assign h4 = {{52{hum_cal_reg[43]}}, hum_cal_reg[43:32]};
    assign h5 = {{52{hum_cal_reg[55]}}, hum_cal_reg[55:44]};
    assign h6 = {{56{hum_cal_reg[63]}}, hum_cal_reg[63:56]};

    assign raw64 = {44'd0, raw_reg};
    assign pa    = {{32{fine_reg[31]}}, fine_reg} - 64'd128000;
    assign hx    = src_pkg::s32({32'd0, fine_reg} - 64'd76800);
    assign x2s13 = src_pkg::asr64(x2_reg, 13);
    assign hv    = src_pkg::s32(x0_reg - src_pkg::asr32(prod, 4));

    src_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (prod)
    );

    src_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (quot)
    );

    assign s_axis_tready = (state_reg == src_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // Calibration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg   <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
            press_last_reg <= '0;
            hum_cal_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                src_pkg::REG_TEMP_CAL:   temp_cal_reg   <= cfg_wdata[47:0];
                src_pkg::REG_PRESS_LOW:  press_low_reg  <= cfg_wdata;
                src_pkg::REG_PRESS_HIGH: press_high_reg <= cfg_wdata;
                src_pkg::REG_PRESS_LAST: press_last_reg <= cfg_wdata[15:0];
                src_pkg::REG_HUM_CAL:    hum_cal_reg    <= cfg_wdata;
                default:                 ;
            endcase
        end
    end

    // Control state, step, kind, output valid flag and stored fine temperature.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= src_pkg::ST_IDLE;
            fine_reg      <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            kind_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fine_reg      <= fine_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            kind_reg      <= kind_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        raw_reg       <= raw_next;
        x0_reg        <= x0_next;
        x1_reg        <= x1_next;
        x2_reg        <= x2_next;
        x3_reg        <= x3_next;
        temp_res_reg  <= temp_res_next;
        press_res_reg <= press_res_next;
        hum_res_reg   <= hum_res_next;
        dz_res_reg    <= dz_res_next;
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
    end

    // Multiplier operands for each step of each kind.
    always_comb
    begin
        mul_req.start = (state_reg == src_pkg::ST_MUL_ISSUE);
        mul_req.a     = '0;
        mul_req.b     = '0;
        unique case (kind_reg)
            src_pkg::KIND_TEMP:
            begin
                unique case (step_reg)
                    4'd0:
                    begin
                        mul_req.a = src_pkg::s32((raw64 >> 3) - (t1 << 1));
                        mul_req.b = t2;
                    end
                    4'd1:
                    begin
                        mul_req.a = src_pkg::s32((raw64 >> 4) - t1);
                        mul_req.b = src_pkg::s32((raw64 >> 4) - t1);
                    end
                    4'd2:
                    begin
                        mul_req.a = x1_reg;
                        mul_req.b = t3;
                    end
                    default:
                    begin
                        mul_req.a = {{32{fine_reg[31]}}, fine_reg};
                        mul_req.b = 64'd5;
                    end
                endcase
            end
            src_pkg::KIND_PRESS:
            begin
                unique case (step_reg)
                    4'd0:    begin mul_req.a = pa;     mul_req.b = pa;  end
                    4'd1:    begin mul_req.a = x0_reg; mul_req.b = p6;  end
                    4'd2:    begin mul_req.a = pa;     mul_req.b = p5;  end
                    4'd3:    begin mul_req.a = x0_reg; mul_req.b = p3;  end
                    4'd4:    begin mul_req.a = pa;     mul_req.b = p2;  end
                    4'd5:
                    begin
                        mul_req.a = (64'd1 << 47) + x0_reg;
                        mul_req.b = p1;
                    end
                    4'd6:
                    begin
                        mul_req.a = ((64'd1048576 - raw64) << 31) - x1_reg;
                        mul_req.b = 64'd3125;
                    end
                    4'd8:    begin mul_req.a = p9;     mul_req.b = x2s13; end
                    4'd9:    begin mul_req.a = x0_reg; mul_req.b = x2s13; end
                    default: begin mul_req.a = p8;     mul_req.b = x2_reg; end
                endcase
            end
            default:
            begin
                unique case (step_reg)
                    4'd0:    begin mul_req.a = h5;     mul_req.b = hx;     end
                    4'd1:    begin mul_req.a = hx;     mul_req.b = h6;     end
                    4'd2:    begin mul_req.a = hx;     mul_req.b = h3;     end
                    4'd3:    begin mul_req.a = x1_reg; mul_req.b = x2_reg; end
                    4'd4:    begin mul_req.a = x1_reg; mul_req.b = h2;     end
                    4'd5:    begin mul_req.a = x0_reg; mul_req.b = x1_reg; end
                    4'd6:    begin mul_req.a = x3_reg; mul_req.b = x3_reg; end
                    default: begin mul_req.a = x1_reg; mul_req.b = h1;     end
                endcase
            end
        endcase
    end

    assign div_req.start = (state_reg == src_pkg::ST_DIV_ISSUE);
    assign div_req.a     = x1_reg;
    assign div_req.b     = x0_reg;

    // Sequencer: next state and the post-processing of each product.
    always_comb
    begin
        state_next     = state_reg;
        fine_next      = fine_reg;
        kind_next      = kind_reg;
        raw_next       = raw_reg;
        step_next      = step_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        x2_next        = x2_reg;
        x3_next        = x3_reg;
        temp_res_next  = temp_res_reg;
        press_res_next = press_res_reg;
        hum_res_next   = hum_res_reg;
        dz_res_next    = dz_res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            src_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    kind_next      = s_axis_tuser;
                    raw_next       = s_axis_tdata[19:0];
                    step_next      = '0;
                    temp_res_next  = '0;
                    press_res_next = '0;
                    hum_res_next   = '0;
                    dz_res_next    = 1'b0;
                    if (s_axis_tuser == src_pkg::KIND_TEMP ||
                        s_axis_tuser == src_pkg::KIND_PRESS ||
                        s_axis_tuser == src_pkg::KIND_HUM)
                    begin
                        state_next = src_pkg::ST_MUL_ISSUE;
                    end
                    else
                    begin
                        state_next = src_pkg::ST_OUT;
                    end
                end
            end

            src_pkg::ST_MUL_ISSUE:
            begin
                state_next = src_pkg::ST_MUL_WAIT;
            end

            src_pkg::ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = src_pkg::ST_MUL_ISSUE;
                    unique case (kind_reg)
                        src_pkg::KIND_TEMP:
                        begin
                            unique case (step_reg)
                                4'd0: x0_next = src_pkg::asr32(prod, 11);
                                4'd1: x1_next = src_pkg::asr32(prod, 12);
                                4'd2:
                                begin
                                    fine_next = 32'(x0_reg + src_pkg::asr32(prod, 14));
                                end
                                default:
                                begin
                                    temp_res_next = 32'(src_pkg::asr32(prod + 64'd128, 8));
                                end
                            endcase
                            if (step_reg == src_pkg::TEMP_LAST_STEP)
                            begin
                                state_next = src_pkg::ST_OUT;
                            end
                        end
                        src_pkg::KIND_PRESS:
                        begin
                            unique case (step_reg)
                                4'd0: x0_next = prod;
                                4'd1: x1_next = prod;
                                4'd2: x1_next = x1_reg + (prod << 17) + (p4 << 35);
                                4'd3: x0_next = src_pkg::asr64(prod, 8);
                                4'd4: x0_next = x0_reg + (prod << 12);
                                4'd5:
                                begin
                                    x0_next = src_pkg::asr64(prod, 33);
                                    if (src_pkg::asr64(prod, 33) == '0)
                                    begin
                                        dz_res_next = 1'b1;
                                        state_next  = src_pkg::ST_OUT;
                                    end
                                end
                                4'd6:
                                begin
                                    x1_next    = prod;
                                    state_next = src_pkg::ST_DIV_ISSUE;
                                end
                                4'd8: x0_next = prod;
                                4'd9: x0_next = src_pkg::asr64(prod, 25);
                                default:
                                begin
                                    press_res_next = 32'(src_pkg::asr64(x2_reg + x0_reg +
                                                     src_pkg::asr64(prod, 19), 8) +
                                                     (p7 << 4));
                                    state_next     = src_pkg::ST_OUT;
                                end
                            endcase
                        end
                        default:
                        begin
                            unique case (step_reg)
                                4'd0:
                                begin
                                    x0_next = src_pkg::asr32((raw64[15:0] << 14) -
                                              (h4 << 20) - prod + 64'd16384, 15);
                                end
                                4'd1: x1_next = src_pkg::asr32(prod, 10);
                                4'd2:
                                begin
                                    x2_next = src_pkg::s32(src_pkg::asr32(prod, 11) +
                                                           64'd32768);
                                end
                                4'd3:
                                begin
                                    x1_next = src_pkg::s32(src_pkg::asr32(prod, 10) +
                                                           64'd2097152);
                                end
                                4'd4: x1_next = src_pkg::asr32(prod + 64'd8192, 14);
                                4'd5:
                                begin
                                    x0_next = src_pkg::s32(prod);
                                    x3_next = src_pkg::asr32(prod, 15);
                                end
                                4'd6: x1_next = src_pkg::asr32(prod, 7);
                                default:
                                begin
                                    // Clamp to the valid range, then drop 12 fraction bits.
                                    if (hv[31])
                                    begin
                                        hum_res_next = '0;
                                    end
                                    else if (hv[31:0] > src_pkg::HUM_LIMIT)
                                    begin
                                        hum_res_next = src_pkg::HUM_LIMIT[28:12];
                                    end
                                    else
                                    begin
                                        hum_res_next = hv[28:12];
                                    end
                                end
                            endcase
                            if (step_reg == src_pkg::HUM_LAST_STEP)
                            begin
                                state_next = src_pkg::ST_OUT;
                            end
                        end
                    endcase
                end
            end

            src_pkg::ST_DIV_ISSUE:
            begin
                state_next = src_pkg::ST_DIV_WAIT;
            end

            src_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    x2_next    = quot;
                    step_next  = src_pkg::PRESS_DIV_STEP + 4'd2;
                    state_next = src_pkg::ST_MUL_ISSUE;
                end
            end

            src_pkg::ST_OUT:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {7'd0, hum_res_reg, press_res_reg, temp_res_reg};
                    out_user_next  = {dz_res_reg, kind_reg};
                    state_next     = src_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = src_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
